FILE: rtl/dsfmt_pkg.sv
// Shared types and constants for the dSFMT uniform generator.
// Used by dsfmt_ctrl, dsfmt_dp and dsfmt_uniform_generator_unit; no dependencies.
package dsfmt_pkg;

    localparam int NUM_PAIRS   = 191;
    localparam int LAG         = 117;
    localparam int DATA_WORDS  = 2 * NUM_PAIRS;
    localparam int TABLE_WORDS = DATA_WORDS + 2;
    localparam int SEED_STEPS  = 2 * TABLE_WORDS - 1;
    localparam int MAX_FETCH   = 64;

    localparam int ADDR_W  = 9;
    localparam int PAIR_W  = 8;
    localparam int STEP_W  = 10;
    localparam int COUNT_W = 7;
    localparam int FRAC_W  = 52;
    localparam int WORD_W  = 64;
    localparam int HALF_W  = 32;

    localparam int MIX_SHL = 19;
    localparam int MIX_SHR = 12;
    localparam int SEED_SHR = 30;

    localparam logic [WORD_W-1:0]  LOW_MASK   = 64'h000f_fafff_ffffb3f;
    localparam logic [WORD_W-1:0]  HIGH_MASK  = 64'h000f_fdff_fc90_fffd;
    localparam logic [HALF_W-1:0]  SEED_MULT  = 32'd1812433253;
    localparam logic [HALF_W-1:0]  HI_KEEP    = 32'h000f_ffff;
    localparam logic [HALF_W-1:0]  HI_EXP     = 32'h3ff0_0000;

    localparam logic [ADDR_W-1:0]  LUNG_A_ADDR = ADDR_W'(DATA_WORDS);
    localparam logic [ADDR_W-1:0]  LUNG_B_ADDR = ADDR_W'(DATA_WORDS + 1);
    localparam logic [PAIR_W-1:0]  LAST_PAIR   = PAIR_W'(NUM_PAIRS - 1);
    localparam logic [PAIR_W-1:0]  LAG_PAIR    = PAIR_W'(LAG);
    localparam logic [STEP_W-1:0]  LAST_STEP   = STEP_W'(SEED_STEPS - 1);
    localparam logic [COUNT_W-1:0] FETCH_LIMIT = COUNT_W'(MAX_FETCH);

    localparam logic KIND_FETCH   = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    typedef enum logic [3:0] {
        S_SEED,
        S_IDLE,
        S_FETCH,
        S_RG_L1,
        S_RG_START,
        S_RG_A1,
        S_RG_B,
        S_RG_B1,
        S_RG_WR,
        S_RG_LW0,
        S_RG_LW1
    } state_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_SEED_START,
        OP_SEED_STEP,
        OP_LUNG_RD0,
        OP_LUNG_RD1,
        OP_PAIR_START,
        OP_PAIR_RD_A1,
        OP_PAIR_RD_B,
        OP_PAIR_RD_B1,
        OP_PAIR_WR,
        OP_LUNG_WR0,
        OP_LUNG_WR1,
        OP_FETCH_RD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   last;
    } cmd_t;

    typedef struct packed {
        logic seed_done;
        logic pair_last;
        logic need_regen;
    } sts_t;

endpackage

FILE: rtl/dsfmt_ctrl.sv
// Controller state machine for the dSFMT uniform generator.
// Depends on dsfmt_pkg; drives dsfmt_dp through cmd_t and reads sts_t.
module dsfmt_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         kind,
    input  logic [dsfmt_pkg::COUNT_W-1:0] count,
    input  dsfmt_pkg::sts_t              sts,
    output dsfmt_pkg::cmd_t              cmd,
    output logic                         busy
);

    dsfmt_pkg::state_t           state_reg, state_next;
    logic [dsfmt_pkg::COUNT_W-1:0] left_reg, left_next;
    logic [dsfmt_pkg::COUNT_W-1:0] count_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsfmt_pkg::S_SEED;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
        end
    end

    assign count_sat = (count > dsfmt_pkg::FETCH_LIMIT) ? dsfmt_pkg::FETCH_LIMIT : count;
    assign busy      = (state_reg != dsfmt_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        left_next  = left_reg;
        cmd.op     = dsfmt_pkg::OP_IDLE;
        cmd.last   = 1'b0;
        unique case (state_reg)
            dsfmt_pkg::S_SEED:
            begin
                cmd.op = dsfmt_pkg::OP_SEED_STEP;
                if (sts.seed_done)
                begin
                    state_next = dsfmt_pkg::S_IDLE;
                end
            end
            dsfmt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (kind == dsfmt_pkg::KIND_RESTART)
                    begin
                        cmd.op     = dsfmt_pkg::OP_SEED_START;
                        state_next = dsfmt_pkg::S_SEED;
                    end
                    else if (count_sat != '0)
                    begin
                        left_next  = count_sat;
                        state_next = dsfmt_pkg::S_FETCH;
                    end
                end
            end
            dsfmt_pkg::S_FETCH:
            begin
                if (sts.need_regen)
                begin
                    cmd.op     = dsfmt_pkg::OP_LUNG_RD0;
                    state_next = dsfmt_pkg::S_RG_L1;
                end
                else
                begin
                    cmd.op    = dsfmt_pkg::OP_FETCH_RD;
                    cmd.last  = (left_reg == dsfmt_pkg::COUNT_W'(1));
                    left_next = left_reg - dsfmt_pkg::COUNT_W'(1);
                    if (left_reg == dsfmt_pkg::COUNT_W'(1))
                    begin
                        state_next = dsfmt_pkg::S_IDLE;
                    end
                end
            end
            dsfmt_pkg::S_RG_L1:
            begin
                cmd.op     = dsfmt_pkg::OP_LUNG_RD1;
                state_next = dsfmt_pkg::S_RG_START;
            end
            dsfmt_pkg::S_RG_START:
            begin
                cmd.op     = dsfmt_pkg::OP_PAIR_START;
                state_next = dsfmt_pkg::S_RG_A1;
            end
            dsfmt_pkg::S_RG_A1:
            begin
                cmd.op     = dsfmt_pkg::OP_PAIR_RD_A1;
                state_next = dsfmt_pkg::S_RG_B;
            end
            dsfmt_pkg::S_RG_B:
            begin
                cmd.op     = dsfmt_pkg::OP_PAIR_RD_B;
                state_next = dsfmt_pkg::S_RG_B1;
            end
            dsfmt_pkg::S_RG_B1:
            begin
                cmd.op     = dsfmt_pkg::OP_PAIR_RD_B1;
                state_next = dsfmt_pkg::S_RG_WR;
            end
            dsfmt_pkg::S_RG_WR:
            begin
                cmd.op = dsfmt_pkg::OP_PAIR_WR;
                if (sts.pair_last)
                begin
                    state_next = dsfmt_pkg::S_RG_LW0;
                end
                else
                begin
                    state_next = dsfmt_pkg::S_RG_A1;
                end
            end
            dsfmt_pkg::S_RG_LW0:
            begin
                cmd.op     = dsfmt_pkg::OP_LUNG_WR0;
                state_next = dsfmt_pkg::S_RG_LW1;
            end
            dsfmt_pkg::S_RG_LW1:
            begin
                cmd.op     = dsfmt_pkg::OP_LUNG_WR1;
                state_next = dsfmt_pkg::S_FETCH;
            end
            default:
            begin
                state_next = dsfmt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/dsfmt_dp.sv
// Datapath of the dSFMT uniform generator: state table, seeding recurrence,
// pair mixing and result registers. Depends on dsfmt_pkg; commanded by dsfmt_ctrl.
module dsfmt_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [dsfmt_pkg::HALF_W-1:0]      seed,
    input  dsfmt_pkg::cmd_t                   cmd,
    output dsfmt_pkg::sts_t                   sts,
    output logic [dsfmt_pkg::FRAC_W-1:0]      fraction,
    output logic                              last,
    output logic                              strobe
);

    logic [dsfmt_pkg::WORD_W-1:0] mem [dsfmt_pkg::TABLE_WORDS];
    logic [dsfmt_pkg::WORD_W-1:0] mem_q;

    logic [dsfmt_pkg::HALF_W-1:0] v_reg, v_next;
    logic [dsfmt_pkg::STEP_W-1:0] k_reg, k_inc;
    logic [dsfmt_pkg::PAIR_W-1:0] i_reg, j_reg;
    logic [dsfmt_pkg::ADDR_W-1:0] rd_idx_reg;
    logic                         fresh_reg;
    logic                         strobe_reg, last_reg;

    logic [dsfmt_pkg::WORD_W-1:0] la_reg, lb_reg, la_old_reg, ta_reg, ta1_reg;

    logic [dsfmt_pkg::HALF_W-1:0] v_mix, seed_hi;
    logic [dsfmt_pkg::WORD_W-1:0] la_calc, lb_calc, ta_new, ta1_new;
    logic [dsfmt_pkg::PAIR_W-1:0] i_inc;

    logic                         we;
    logic [dsfmt_pkg::ADDR_W-1:0] wr_addr, rd_addr;
    logic [dsfmt_pkg::WORD_W-1:0] wr_data;

    // Seeding recurrence: one step per cycle, the product is truncated to 32 bits.
    assign k_inc   = k_reg + dsfmt_pkg::STEP_W'(1);
    assign v_mix   = v_reg ^ (v_reg >> dsfmt_pkg::SEED_SHR);
    assign v_next  = (v_mix * dsfmt_pkg::SEED_MULT)
                   + {{(dsfmt_pkg::HALF_W-dsfmt_pkg::STEP_W){1'b0}}, k_inc};
    assign seed_hi = (k_reg[dsfmt_pkg::STEP_W-1:1] < dsfmt_pkg::LUNG_A_ADDR)
                   ? ((v_next & dsfmt_pkg::HI_KEEP) | dsfmt_pkg::HI_EXP) : v_next;

    // Pair mixing. The second word of each pair uses the lung value from
    // before the first word updated it.
    assign la_calc = (ta_reg << dsfmt_pkg::MIX_SHL) ^ mem_q
                   ^ {lb_reg[dsfmt_pkg::HALF_W-1:0], lb_reg[dsfmt_pkg::WORD_W-1:dsfmt_pkg::HALF_W]};
    assign ta_new  = (la_calc >> dsfmt_pkg::MIX_SHR) ^ ta_reg ^ (la_calc & dsfmt_pkg::LOW_MASK);
    assign lb_calc = (ta1_reg << dsfmt_pkg::MIX_SHL) ^ mem_q
                   ^ {la_old_reg[dsfmt_pkg::HALF_W-1:0],
                      la_old_reg[dsfmt_pkg::WORD_W-1:dsfmt_pkg::HALF_W]};
    assign ta1_new = (lb_calc >> dsfmt_pkg::MIX_SHR) ^ ta1_reg ^ (lb_calc & dsfmt_pkg::HIGH_MASK);

    assign i_inc = i_reg + dsfmt_pkg::PAIR_W'(1);

    always_comb
    begin
        we      = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        rd_addr = rd_idx_reg;
        unique case (cmd.op)
            dsfmt_pkg::OP_SEED_STEP:
            begin
                we      = ~k_reg[0];
                wr_addr = k_reg[dsfmt_pkg::STEP_W-1:1];
                wr_data = {seed_hi, v_reg};
            end
            dsfmt_pkg::OP_LUNG_RD0:   rd_addr = dsfmt_pkg::LUNG_A_ADDR;
            dsfmt_pkg::OP_LUNG_RD1:   rd_addr = dsfmt_pkg::LUNG_B_ADDR;
            dsfmt_pkg::OP_PAIR_START: rd_addr = {i_reg, 1'b0};
            dsfmt_pkg::OP_PAIR_RD_A1: rd_addr = {i_reg, 1'b1};
            dsfmt_pkg::OP_PAIR_RD_B:  rd_addr = {j_reg, 1'b0};
            dsfmt_pkg::OP_PAIR_RD_B1:
            begin
                rd_addr = {j_reg, 1'b1};
                we      = 1'b1;
                wr_addr = {i_reg, 1'b0};
                wr_data = ta_new;
            end
            dsfmt_pkg::OP_PAIR_WR:
            begin
                rd_addr = {i_inc, 1'b0};
                we      = 1'b1;
                wr_addr = {i_reg, 1'b1};
                wr_data = ta1_new;
            end
            dsfmt_pkg::OP_LUNG_WR0:
            begin
                we      = 1'b1;
                wr_addr = dsfmt_pkg::LUNG_A_ADDR;
                wr_data = la_reg;
            end
            dsfmt_pkg::OP_LUNG_WR1:
            begin
                we      = 1'b1;
                wr_addr = dsfmt_pkg::LUNG_B_ADDR;
                wr_data = lb_reg;
            end
            default:
            begin
                rd_addr = rd_idx_reg;
            end
        endcase
    end

    // State table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg      <= '0;
            k_reg      <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            rd_idx_reg <= '0;
            fresh_reg  <= 1'b0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= (cmd.op == dsfmt_pkg::OP_FETCH_RD);
            last_reg   <= (cmd.op == dsfmt_pkg::OP_FETCH_RD) && cmd.last;
            unique case (cmd.op)
                dsfmt_pkg::OP_SEED_START:
                begin
                    v_reg      <= seed;
                    k_reg      <= '0;
                    rd_idx_reg <= '0;
                    fresh_reg  <= 1'b0;
                end
                dsfmt_pkg::OP_SEED_STEP:
                begin
                    v_reg <= v_next;
                    k_reg <= k_inc;
                end
                dsfmt_pkg::OP_LUNG_RD0:
                begin
                    i_reg <= '0;
                    j_reg <= dsfmt_pkg::LAG_PAIR;
                end
                dsfmt_pkg::OP_PAIR_WR:
                begin
                    i_reg <= i_inc;
                    j_reg <= (j_reg == dsfmt_pkg::LAST_PAIR) ? '0
                           : j_reg + dsfmt_pkg::PAIR_W'(1);
                end
                dsfmt_pkg::OP_LUNG_WR1:
                begin
                    rd_idx_reg <= '0;
                    fresh_reg  <= 1'b1;
                end
                dsfmt_pkg::OP_FETCH_RD:
                begin
                    rd_idx_reg <= rd_idx_reg + dsfmt_pkg::ADDR_W'(1);
                end
                default:
                begin
                    fresh_reg <= fresh_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            dsfmt_pkg::OP_LUNG_RD1:   la_reg  <= mem_q;
            dsfmt_pkg::OP_PAIR_START: lb_reg  <= mem_q;
            dsfmt_pkg::OP_PAIR_RD_A1: ta_reg  <= mem_q;
            dsfmt_pkg::OP_PAIR_RD_B:  ta1_reg <= mem_q;
            dsfmt_pkg::OP_PAIR_RD_B1:
            begin
                la_reg     <= la_calc;
                la_old_reg <= la_reg;
            end
            dsfmt_pkg::OP_PAIR_WR:    lb_reg  <= lb_calc;
            default:
            begin
                ta_reg <= ta_reg;
            end
        endcase
    end

    assign sts.seed_done  = (k_reg == dsfmt_pkg::LAST_STEP);
    assign sts.pair_last  = (i_reg == dsfmt_pkg::LAST_PAIR);
    assign sts.need_regen = !fresh_reg || (rd_idx_reg == dsfmt_pkg::LUNG_A_ADDR);

    assign fraction = mem_q[dsfmt_pkg::FRAC_W-1:0];
    assign last     = last_reg;
    assign strobe   = strobe_reg;

endmodule

FILE: rtl/dsfmt_uniform_generator_unit.sv
// Top level of the dSFMT (19937) uniform generator: seed register,
// controller and datapath. Depends on dsfmt_pkg, dsfmt_ctrl and dsfmt_dp.
//
// Usage: a command is taken on a clock edge where start is high and busy is
// low. A fetch (kind 0) returns count values (count above 64 gives 64, count
// 0 gives none), one beat per clock on fraction/last marked by strobe, with
// last set on the final beat. The receiver cannot stall: every beat is
// present for exactly one cycle and must be captured then. Each beat is read
// in the fetch state and leaves the registered read port with strobe, and
// beats follow back to back, except that whenever the 382 data words of the
// table are used up the table is regenerated in place, which inserts a gap
// (lung read, then for each of the 191 pairs the reads of both words of
// pairs i and j and the write-back of both new words through the table
// RAM's one read and one write port, lung write back). The first fetch after
// a restart or reset always regenerates. A restart (kind 1) reseeds the
// table from the seed register with the multiplicative recurrence, one step
// per cycle, keeping busy high until the seeding is done. After reset the
// same seeding runs with seed 0 before the first command is taken. The seed
// register is written through cfg_valid/cfg_ready/cfg_data, which is always
// ready; write it only while the block is idle.
module dsfmt_uniform_generator_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              kind,
    input  logic [dsfmt_pkg::COUNT_W-1:0]     count,
    output logic                              strobe,
    output logic [dsfmt_pkg::FRAC_W-1:0]      fraction,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dsfmt_pkg::HALF_W-1:0]      cfg_data
);

    logic [dsfmt_pkg::HALF_W-1:0] seed_reg;
    dsfmt_pkg::cmd_t              cmd;
    dsfmt_pkg::sts_t              sts;

    // The seed register takes a beat on any cycle; it is only sampled when a
    // restart command begins.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            seed_reg <= cfg_data;
        end
    end

    dsfmt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .count (count),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    dsfmt_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .seed     (seed_reg),
        .cmd      (cmd),
        .sts      (sts),
        .fraction (fraction),
        .last     (last),
        .strobe   (strobe)
    );

    // A result beat always comes from a read issued while a fetch was running.
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result beat without a running fetch");

    // A beat that is not the final one leaves the fetch still running.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> busy)
        else $error("fetch ended before its final beat");

    // A restart always occupies the block on the following cycle.
    a_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == dsfmt_pkg::KIND_RESTART)) |=> busy)
        else $error("restart not started");

    // A nonempty fetch always occupies the block on the following cycle.
    a_fetch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == dsfmt_pkg::KIND_FETCH) && (count != '0)) |=> busy)
        else $error("fetch not started");

endmodule
